FILE: hw/rtl/mpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot pixel color package
// Shared types, palette table and register codes.
// ----------------------------------------------------------------------------
package mpc_pkg;

   localparam int FRAC_BITS = 28;
   localparam int PALETTE_SIZE = 16;

   typedef enum logic [2:0] {
      REG_X_MIN = 3'd0,
      REG_Y_MIN = 3'd1,
      REG_STEP_X = 3'd2,
      REG_STEP_Y = 3'd3,
      REG_LIMIT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Z value handed between the cells of the iteration chain
   typedef struct packed {
      logic signed [31:0] zr;
      logic signed [31:0] zi;
      logic [31:0] x2;
      logic [31:0] y2;
   } z_type;

   // Products registered by the multiply cell
   typedef struct packed {
      logic signed [63:0] rr;
      logic signed [63:0] ii;
      logic signed [63:0] ri;
   } prod_type;

   localparam rgb_type DARK_COLOR = '{8'd16, 8'd16, 8'd16};

   function automatic rgb_type palette_lookup(input logic [3:0] idx);
      rgb_type c;
      case (idx)
         4'd0: c = '{8'd66, 8'd30, 8'd15};
         4'd1: c = '{8'd25, 8'd7, 8'd26};
         4'd2: c = '{8'd9, 8'd1, 8'd47};
         4'd3: c = '{8'd4, 8'd4, 8'd73};
         4'd4: c = '{8'd0, 8'd7, 8'd100};
         4'd5: c = '{8'd12, 8'd44, 8'd138};
         4'd6: c = '{8'd24, 8'd82, 8'd177};
         4'd7: c = '{8'd57, 8'd125, 8'd209};
         4'd8: c = '{8'd134, 8'd181, 8'd229};
         4'd9: c = '{8'd211, 8'd236, 8'd248};
         4'd10: c = '{8'd241, 8'd233, 8'd191};
         4'd11: c = '{8'd248, 8'd201, 8'd95};
         4'd12: c = '{8'd255, 8'd170, 8'd0};
         4'd13: c = '{8'd204, 8'd128, 8'd0};
         4'd14: c = '{8'd153, 8'd87, 8'd0};
         default: c = '{8'd106, 8'd52, 8'd3};
      endcase
      return c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -35'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

FILE: hw/rtl/mpc_mult_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot multiply cell
// Forms zr*zr, zi*zi and zr*zi of the z value it receives, registered.
// ----------------------------------------------------------------------------
module mpc_mult_cell (
   input  logic              clock,
   input  logic              en,
   input  mpc_pkg::z_type    z_in,
   output mpc_pkg::prod_type prod
);

   mpc_pkg::prod_type prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff.rr <= 64'(z_in.zr) * 64'(z_in.zr);
         prod_ff.ii <= 64'(z_in.zi) * 64'(z_in.zi);
         prod_ff.ri <= 64'(z_in.zr) * 64'(z_in.zi);
      end
   end

   assign prod = prod_ff;

endmodule

FILE: hw/rtl/mpc_update_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot update cell
// Forms the next z from the registered products of the previous z.
// ----------------------------------------------------------------------------
module mpc_update_cell (
   input  logic                clock,
   input  logic                load,
   input  logic                en,
   input  logic signed [31:0]  c_re,
   input  logic signed [31:0]  c_im,
   input  mpc_pkg::z_type      z_prev,
   input  mpc_pkg::prod_type   prod,
   output mpc_pkg::z_type      z_out
);

   mpc_pkg::z_type z_ff;
   mpc_pkg::z_type z_in;
   logic signed [34:0] im_sum;
   logic signed [34:0] re_sum;
   logic signed [63:0] ri_shift;

   always_comb begin
      z_in = z_ff;
      ri_shift = prod.ri >>> (mpc_pkg::FRAC_BITS - 1);
      if (ri_shift > 64'sh1_FFFF_FFFF)
         im_sum = 35'sh1_FFFF_FFFF;
      else if (ri_shift < -64'sh2_0000_0000)
         im_sum = -35'sh2_0000_0000;
      else
         im_sum = 35'(ri_shift);
      im_sum = im_sum + 35'(c_im);
      re_sum = 35'($signed({1'b0, z_prev.x2})) - 35'($signed({1'b0, z_prev.y2}))
             + 35'(c_re);
      if (load) begin
         z_in = '0;
      end else if (en) begin
         z_in.zi = mpc_pkg::sat32(im_sum);
         z_in.zr = mpc_pkg::sat32(re_sum);
         z_in.x2 = z_prev.x2;
         z_in.y2 = z_prev.y2;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   assign z_out = z_ff;

endmodule

FILE: hw/rtl/mpc_square_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot square cell
// Multiplies the new z and forms the saturated squares for the escape test.
// ----------------------------------------------------------------------------
module mpc_square_cell (
   input  logic            clock,
   input  logic            load,
   input  logic            en,
   input  mpc_pkg::z_type  z_new,
   output mpc_pkg::z_type  z_sq
);

   mpc_pkg::z_type z_ff;
   mpc_pkg::z_type z_in;
   logic [63:0] rr;
   logic [63:0] ii;

   always_comb begin
      rr = 64'(64'(z_new.zr) * 64'(z_new.zr)) >> mpc_pkg::FRAC_BITS;
      ii = 64'(64'(z_new.zi) * 64'(z_new.zi)) >> mpc_pkg::FRAC_BITS;
      z_in = z_ff;
      if (load) begin
         z_in = '0;
      end else if (en) begin
         z_in.zr = z_new.zr;
         z_in.zi = z_new.zi;
         z_in.x2 = (rr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rr[31:0];
         z_in.y2 = (ii > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ii[31:0];
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   assign z_sq = z_ff;

endmodule

FILE: hw/rtl/mandelbrot_pixel_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot pixel color
// Escape-time iteration for one pixel and palette coloring.
// ----------------------------------------------------------------------------
// channel  direction  contents
// req      in         tdata: col_index, row_index
// rsp      out        tdata: red, green, blue, escape_count
// csr      in/out     APB registers x_min, y_min, step_x, step_y, iteration_limit
//
// A request forms c in the states S_POINT and S_SNAP, then each iteration passes
// through the chain multiply cell -> update cell -> square cell -> escape test; the
// result is registered at the last escape test (a limit of zero goes straight there).
// One request in flight; the next is taken while the result waits in the
// output register, and the last escape test holds until that register is free.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_color #(
   parameter int INDEX_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // col_index[13:0], row_index[27:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red, green, blue, escape_count
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_POINT, S_SNAP, S_MULT, S_UPD, S_SQ, S_DONE
   } state_type;

   state_type state_ff;
   logic signed [31:0] x_min_ff, y_min_ff;
   logic [30:0] step_x_ff, step_y_ff;
   logic [15:0] limit_ff;
   logic [INDEX_BITS-1:0] col_ff, row_ff;
   logic signed [47:0] re_acc_ff, im_acc_ff;
   logic signed [31:0] c_re_ff, c_im_ff;
   logic [15:0] count_ff;
   logic rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   mpc_pkg::z_type z_upd, z_sq;
   mpc_pkg::prod_type prod;
   logic load;
   logic [32:0] mag_sum;
   logic signed [31:0] c_im_sat;
   logic [31:0] c_im_mag;
   logic [3:0] pal_idx;
   mpc_pkg::rgb_type color;

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign load = (state_ff == S_SNAP);

   always_comb begin
      unique case (mpc_pkg::reg_index_type'(csr_paddr[4:2]))
         mpc_pkg::REG_X_MIN: csr_prdata = x_min_ff;
         mpc_pkg::REG_Y_MIN: csr_prdata = y_min_ff;
         mpc_pkg::REG_STEP_X: csr_prdata = {1'b0, step_x_ff};
         mpc_pkg::REG_STEP_Y: csr_prdata = {1'b0, step_y_ff};
         mpc_pkg::REG_LIMIT: csr_prdata = {16'd0, limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   mpc_mult_cell u_mult (
      .clock(clock), .en(state_ff == S_MULT), .z_in(z_sq), .prod(prod)
   );
   mpc_update_cell u_upd (
      .clock(clock), .load(load), .en(state_ff == S_UPD), .c_re(c_re_ff),
      .c_im(c_im_ff), .z_prev(z_sq), .prod(prod), .z_out(z_upd)
   );
   mpc_square_cell u_sq (
      .clock(clock), .load(load), .en(state_ff == S_SQ), .z_new(z_upd), .z_sq(z_sq)
   );

   always_comb begin
      c_im_sat = mpc_pkg::sat32(35'(im_acc_ff > 48'sh7FFF_FFFF ? 48'sh7FFF_FFFF :
                 im_acc_ff < -48'sh8000_0000 ? -48'sh8000_0000 : im_acc_ff));
      c_im_mag = c_im_sat[31] ? 32'(-33'(c_im_sat)) : 32'(c_im_sat);
      mag_sum = {c_im_mag, 1'b0};
      pal_idx = 4'(count_ff % mpc_pkg::PALETTE_SIZE);
      color = (count_ff == limit_ff) ? mpc_pkg::DARK_COLOR : mpc_pkg::palette_lookup(pal_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         x_min_ff <= -32'sd671088640;
         y_min_ff <= -32'sd536870912;
         step_x_ff <= 31'd1048576;
         step_y_ff <= 31'd1048576;
         limit_ff <= 16'd200;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (mpc_pkg::reg_index_type'(csr_paddr[4:2]))
               mpc_pkg::REG_X_MIN: x_min_ff <= csr_pwdata;
               mpc_pkg::REG_Y_MIN: y_min_ff <= csr_pwdata;
               mpc_pkg::REG_STEP_X: step_x_ff <= csr_pwdata[30:0];
               mpc_pkg::REG_STEP_Y: step_y_ff <= csr_pwdata[30:0];
               mpc_pkg::REG_LIMIT: limit_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  col_ff <= req_tdata[INDEX_BITS-1:0];
                  row_ff <= req_tdata[INDEX_BITS +: INDEX_BITS];
                  state_ff <= S_POINT;
               end
            end
            S_POINT: begin
               re_acc_ff <= 48'(x_min_ff) + 48'($signed({1'b0, col_ff}))
                            * 48'($signed({1'b0, step_x_ff}));
               im_acc_ff <= 48'(y_min_ff) + 48'($signed({1'b0, row_ff}))
                            * 48'($signed({1'b0, step_y_ff}));
               state_ff <= S_SNAP;
            end
            S_SNAP: begin
               c_re_ff <= mpc_pkg::sat32(35'(re_acc_ff > 48'sh7FFF_FFFF ? 48'sh7FFF_FFFF :
                          re_acc_ff < -48'sh8000_0000 ? -48'sh8000_0000 : re_acc_ff));
               c_im_ff <= (mag_sum < {2'b0, step_y_ff}) ? 32'sd0 : c_im_sat;
               count_ff <= '0;
               state_ff <= (limit_ff == 16'd0) ? S_DONE : S_MULT;
            end
            S_MULT: state_ff <= S_UPD;
            S_UPD: state_ff <= S_SQ;
            S_SQ: begin
               count_ff <= count_ff + 16'd1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (count_ff < limit_ff &&
                   (33'(z_sq.x2) + 33'(z_sq.y2)) < 33'h4000_0000) begin
                  state_ff <= S_MULT;
               end else if (!rsp_valid_ff) begin
                  rsp_data_ff <= {8'd0, count_ff, color.blue, color.green, color.red};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
